/* design/lfu_pkg.sv */
`default_nettype none

package lfu_pkg;

  // Store geometry.
  localparam int ENTRIES    = 16;
  localparam int COUNT_BITS = 16;

  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int USED_BITS = $clog2(ENTRIES + 1);

  // Capacity register and the width used to compare it against occupancy.
  localparam int CAP_BITS = 5;
  localparam int CMP_BITS = (USED_BITS > CAP_BITS) ? USED_BITS : CAP_BITS;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

  localparam int DATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [DATA_BITS-1:0]  MISS_VALUE = '1;

  // Operation codes.
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // One entry as presented to the scan unit in a scan cycle.
  typedef struct packed {
    logic                  valid;
    logic [DATA_BITS-1:0]  key;
    logic [COUNT_BITS-1:0] count;
    logic [RANK_BITS-1:0]  rank;
    logic [IDX_BITS-1:0]   idx;
  } entry_view_t;

  // Sequencer controls for the scan unit.
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // Running outcome of a scan.
  typedef struct packed {
    logic                  match;
    logic [IDX_BITS-1:0]   match_idx;
    logic                  victim_found;
    logic [IDX_BITS-1:0]   victim_idx;
    logic [COUNT_BITS-1:0] victim_count;
    logic [RANK_BITS-1:0]  victim_rank;
    logic                  free_found;
    logic [IDX_BITS-1:0]   free_idx;
    logic [USED_BITS-1:0]  used;
  } scan_res_t;

endpackage

`default_nettype wire

/* design/lfu_scan.sv */
`default_nettype none

// Walks the entries one per step: finds the matching key, the first free
// slot, the occupancy, and the replacement candidate (lowest count, oldest).
module lfu_scan (
  input  wire logic                             clk,
  input  wire lfu_pkg::scan_ctl_t               ctl,
  input  wire logic [lfu_pkg::DATA_BITS-1:0]    search_key,
  input  wire lfu_pkg::entry_view_t             entry,
  output lfu_pkg::scan_res_t                    res
);

  lfu_pkg::scan_res_t res_next;
  logic               better;

  always_comb begin
    better = !res.victim_found || (entry.count < res.victim_count) ||
             ((entry.count == res.victim_count) && (entry.rank > res.victim_rank));
  end

  always_comb begin
    res_next = res;
    if (ctl.clear) begin
      res_next.match        = 1'b0;
      res_next.victim_found = 1'b0;
      res_next.free_found   = 1'b0;
      res_next.used         = '0;
    end else if (ctl.step) begin
      if (entry.valid) begin
        res_next.used = res.used + 1'b1;
        if (!res.match && (entry.key == search_key)) begin
          res_next.match     = 1'b1;
          res_next.match_idx = entry.idx;
        end
        if (better) begin
          res_next.victim_found = 1'b1;
          res_next.victim_idx   = entry.idx;
          res_next.victim_count = entry.count;
          res_next.victim_rank  = entry.rank;
        end
      end else if (!res.free_found) begin
        res_next.free_found = 1'b1;
        res_next.free_idx   = entry.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

/* design/lfu_cache_table_unit.sv */
`default_nettype none

// Channel  Direction  Handshake            Word
// in       input      in_valid / in_ready  opcode, key, value
// out      output     out_valid/out_ready  hit, read_value, evicted, evicted_key
// cfg      input      cfg_we (no wait)     cfg_wdata = capacity
//
// The result word is shown once the input word is taken and the table has
// been scanned entry by entry through the shared compare unit (ST_SCAN) and
// then updated (ST_UPDATE). No new word is taken until the result is taken.
// With capacity zero the scan and update are skipped and the result follows
// acceptance directly.
// in_ready is high only while no access is in flight; a stalled result holds
// the block until it is taken. Reset (rst, synchronous) empties the table and
// sets capacity to 16; entry contents are not cleared.
module lfu_cache_table_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [lfu_pkg::CAP_BITS-1:0]          cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  opcode,
  input  wire logic signed [lfu_pkg::DATA_BITS-1:0]  key,
  input  wire logic signed [lfu_pkg::DATA_BITS-1:0]  value,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       hit,
  output logic signed [lfu_pkg::DATA_BITS-1:0]       read_value,
  output logic                                       evicted,
  output logic signed [lfu_pkg::DATA_BITS-1:0]       evicted_key
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam int IB = lfu_pkg::IDX_BITS;
  localparam int RB = lfu_pkg::RANK_BITS;
  localparam int CB = lfu_pkg::COUNT_BITS;
  localparam int DB = lfu_pkg::DATA_BITS;
  localparam int MB = lfu_pkg::CMP_BITS;

  logic [1:0] state;
  logic [IB-1:0] idx;

  logic [lfu_pkg::CAP_BITS-1:0] capacity;
  logic [MB-1:0] cap_ext;
  logic [MB-1:0] cap_sat;
  logic [MB-1:0] cap_cur;

  // The accepted word.
  logic          op;
  logic [DB-1:0] req_key;
  logic [DB-1:0] req_value;

  // The table: valid bits are reset, contents are written before use.
  logic [lfu_pkg::ENTRIES-1:0] entry_valid;
  logic [DB-1:0] entry_key   [lfu_pkg::ENTRIES];
  logic [DB-1:0] entry_value [lfu_pkg::ENTRIES];
  logic [CB-1:0] entry_count [lfu_pkg::ENTRIES];
  logic [RB-1:0] entry_rank  [lfu_pkg::ENTRIES];

  lfu_pkg::scan_ctl_t   scan_ctl;
  lfu_pkg::entry_view_t view;
  lfu_pkg::scan_res_t   res;

  logic          accept;
  logic          do_evict;
  logic [IB-1:0] ins_idx;
  logic [RB-1:0] hit_rank;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // Capacities above the table size act as the table size.
  assign cap_ext = MB'(capacity);
  assign cap_sat = (cap_ext > MB'(lfu_pkg::ENTRIES)) ? MB'(lfu_pkg::ENTRIES) : cap_ext;

  assign scan_ctl.clear = accept;
  assign scan_ctl.step  = (state == ST_SCAN);

  // Entry under the compare unit this cycle.
  always_comb begin
    view.valid = entry_valid[idx];
    view.key   = entry_key[idx];
    view.count = entry_count[idx];
    view.rank  = entry_rank[idx];
    view.idx   = idx;
  end

  lfu_scan u_scan (
    .clk        (clk),
    .ctl        (scan_ctl),
    .search_key (req_key),
    .entry      (view),
    .res        (res)
  );

  // A new key on a full table replaces the candidate. The new entry takes
  // the lowest free slot, which may be the one just vacated.
  always_comb begin
    do_evict = !res.match && (op == lfu_pkg::OP_PUT) &&
               (MB'(res.used) >= cap_cur) && res.victim_found;
    ins_idx  = res.free_idx;
    if (do_evict && (!res.free_found || (res.victim_idx < res.free_idx))) begin
      ins_idx = res.victim_idx;
    end
    hit_rank = entry_rank[res.match_idx];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            state <= (cap_sat == '0) ? ST_OUT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == IB'(lfu_pkg::ENTRIES - 1)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lfu_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Accepted word and result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= opcode;
      req_key     <= key;
      req_value   <= value;
      cap_cur     <= cap_sat;
      hit         <= 1'b0;
      read_value  <= (opcode == lfu_pkg::OP_GET) ? lfu_pkg::MISS_VALUE : '0;
      evicted     <= 1'b0;
      evicted_key <= '0;
    end else if (state == ST_UPDATE) begin
      if (res.match) begin
        hit <= 1'b1;
        if (op == lfu_pkg::OP_GET) begin
          read_value <= entry_value[res.match_idx];
        end
      end else if (do_evict) begin
        evicted     <= 1'b1;
        evicted_key <= entry_key[res.victim_idx];
      end
    end
  end

  // When the new entry reuses the vacated slot, that slot simply stays valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if ((state == ST_UPDATE) && !res.match && (op == lfu_pkg::OP_PUT)) begin
      if (do_evict && (ins_idx != res.victim_idx)) begin
        entry_valid[res.victim_idx] <= 1'b0;
      end
      if (do_evict || res.free_found) begin
        entry_valid[ins_idx] <= 1'b1;
      end
    end
  end

  // Table update. A touched entry becomes rank zero and every younger entry
  // ages by one. An insert ages every surviving entry by one, except those
  // older than an evicted entry, which close the gap and stay put.
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      if (res.match) begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (entry_valid[i] && (entry_rank[i] < hit_rank)) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
        entry_rank[res.match_idx] <= '0;
        if (entry_count[res.match_idx] != lfu_pkg::COUNT_MAX) begin
          entry_count[res.match_idx] <= entry_count[res.match_idx] + 1'b1;
        end
        if (op == lfu_pkg::OP_PUT) begin
          entry_value[res.match_idx] <= req_value;
        end
      end else if (op == lfu_pkg::OP_PUT && (do_evict || res.free_found)) begin
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (entry_valid[i] && !(do_evict && (IB'(i) == res.victim_idx)) &&
              !(do_evict && (entry_rank[i] > res.victim_rank))) begin
            entry_rank[i] <= entry_rank[i] + 1'b1;
          end
        end
        entry_key[ins_idx]   <= req_key;
        entry_value[ins_idx] <= req_value;
        entry_count[ins_idx] <= lfu_pkg::COUNT_ONE;
        entry_rank[ins_idx]  <= '0;
      end
    end
  end

endmodule

`default_nettype wire
